// ===== hdl/dcr_pkg.sv =====
// ----------------------------------------------------------------------------
// dcr_pkg
// Types, widths and helpers for the disc collision response pipeline.
// ----------------------------------------------------------------------------
package dcr_pkg;

	localparam int CF_W     = 9;
	localparam logic [CF_W-1:0] CF_RESET = 9'd128;

	// square root: 40-bit radicand, one result bit per stage
	localparam int SQ_N     = 20;
	localparam int RAD_W    = 2 * SQ_N;
	localparam int ROOT_W   = SQ_N;
	localparam int SQREM_W  = ROOT_W + 2;

	// dividers
	localparam int QUO_W    = 18;
	localparam int DIV_LAT  = QUO_W + 2;
	localparam int PNUM_W   = 43;
	localparam int PDEN_W   = 29;
	localparam int INUM_W   = 44;
	localparam int IDEN_W   = 24;

	typedef struct packed {
		logic signed [15:0] x1;
		logic signed [15:0] y1;
		logic signed [15:0] vx1;
		logic signed [15:0] vy1;
		logic signed [15:0] x2;
		logic signed [15:0] y2;
		logic signed [15:0] vx2;
		logic signed [15:0] vy2;
	} dcr_item_t;

	typedef struct packed {
		dcr_item_t          item;
		logic [12:0]        dsum;
		logic signed [12:0] dx;
		logic signed [12:0] dy;
		logic [23:0]        dist2;
		logic signed [30:0] dot;
		logic               coll;
		logic               imp;
	} dcr_geo_t;

	typedef struct packed {
		dcr_geo_t            geo;
		logic [SQREM_W-1:0]  rem;
		logic [ROOT_W-1:0]   root;
		logic [RAD_W-1:0]    rad;
	} dcr_sq_t;

	typedef struct packed {
		dcr_item_t item;
		logic      coll;
		logic      imp;
	} dcr_tail_t;

	function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
		logic signed [15:0] r;
		if (v > 20'sd32767) begin
			r = 16'sh7fff;
		end else if (v < -20'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage

// ===== hdl/dcr_div_pipe.sv =====
// ----------------------------------------------------------------------------
// dcr_div_pipe
// Pipelined signed divide, rounded to nearest with halves away from zero.
// One quotient bit per stage, between an input register and an output register.
// ----------------------------------------------------------------------------
module dcr_div_pipe #(
	parameter int NUM_W = 43,
	parameter int DEN_W = 29,
	parameter int QUO_W = 18
) (
	input  logic                    clk,
	input  logic signed [NUM_W-1:0] num,
	input  logic [DEN_W-1:0]        den,
	output logic signed [QUO_W:0]   quo
);

	localparam int REM_W = (NUM_W + 1 > DEN_W + QUO_W) ? NUM_W + 1 : DEN_W + QUO_W;

	logic [REM_W-1:0] rem_s [0:QUO_W];
	logic [DEN_W-1:0] den_s [0:QUO_W];
	logic [QUO_W-1:0] q_s   [0:QUO_W];
	logic             neg_s [0:QUO_W];
	logic [NUM_W-1:0] mag;

	// magnitude plus half the divisor gives the rounding
	assign mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);

	always_ff @(posedge clk) begin
		rem_s[0] <= REM_W'(mag) + REM_W'(den >> 1);
		den_s[0] <= den;
		q_s[0]   <= '0;
		neg_s[0] <= num[NUM_W-1];
	end

	for (genvar j = 1; j <= QUO_W; j++) begin : g_stage
		logic [REM_W-1:0] dsh;
		logic             ge;
		assign dsh = REM_W'(den_s[j-1]) << (QUO_W - j);
		assign ge  = rem_s[j-1] >= dsh;
		always_ff @(posedge clk) begin
			rem_s[j] <= ge ? rem_s[j-1] - dsh : rem_s[j-1];
			den_s[j] <= den_s[j-1];
			q_s[j]   <= {q_s[j-1][QUO_W-2:0], ge};
			neg_s[j] <= neg_s[j-1];
		end
	end

	always_ff @(posedge clk) begin
		quo <= neg_s[QUO_W] ? -$signed({1'b0, q_s[QUO_W]}) : $signed({1'b0, q_s[QUO_W]});
	end

endmodule

// ===== hdl/disc_collision_response.sv =====
// ----------------------------------------------------------------------------
// disc_collision_response
// Equal-mass elastic collision of two discs: overlap push-out and exchange
// of the normal velocity components, fixed point, saturated results.
// ----------------------------------------------------------------------------
// Usage
//   Drive one disc pair on the input ports and pulse start. busy is always
//   low: a pair is taken every cycle that start is high.
//   Each pair yields one result beat, shown for exactly one cycle with done
//   high. Results leave in the order the pairs came in; throughput is one
//   pair per clock. Most of the pipeline is the 20-stage square root (one
//   root bit per stage) and the 18-bit quotient dividers (one quotient bit
//   per stage). correction_factor is written with cfg_wr_en / cfg_wr_data
//   while no pair is in flight: the user must keep to this, the block does
//   not enforce it. It resets to 128 (half correction).
//   arst_n clears the pipeline valid bits, so nothing in flight at reset
//   comes out. The receiver has no way to stall; done is not held.
// ----------------------------------------------------------------------------
module disc_collision_response (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic                      cfg_wr_en,
	input  logic [dcr_pkg::CF_W-1:0]  cfg_wr_data,
	input  logic signed [15:0]        first_x,
	input  logic signed [15:0]        first_y,
	input  logic signed [15:0]        first_vx,
	input  logic signed [15:0]        first_vy,
	input  logic [11:0]               first_diameter,
	input  logic signed [15:0]        second_x,
	input  logic signed [15:0]        second_y,
	input  logic signed [15:0]        second_vx,
	input  logic signed [15:0]        second_vy,
	input  logic [11:0]               second_diameter,
	output logic                      done,
	output logic signed [15:0]        new_first_x,
	output logic signed [15:0]        new_first_y,
	output logic signed [15:0]        new_first_vx,
	output logic signed [15:0]        new_first_vy,
	output logic signed [15:0]        new_second_x,
	output logic signed [15:0]        new_second_y,
	output logic signed [15:0]        new_second_vx,
	output logic signed [15:0]        new_second_vy,
	output logic                      collided,
	output logic                      impulse_applied
);

	import dcr_pkg::*;

	localparam int LAT = SQ_N + DIV_LAT + 7;

	logic [CF_W-1:0] cf_q;
	logic [LAT-1:0]  vld_s;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cf_q  <= CF_RESET;
			vld_s <= '0;
		end else begin
			if (cfg_wr_en) begin
				cf_q <= cfg_wr_data;
			end
			vld_s <= {vld_s[LAT-2:0], start};
		end
	end

	// ---- stage 1: differences ----
	dcr_item_t          item_s1;
	logic signed [16:0] dx_s1, dy_s1, dvx_s1, dvy_s1;
	logic [12:0]        dsum_s1;

	always_ff @(posedge clk) begin
		item_s1 <= '{first_x, first_y, first_vx, first_vy,
			second_x, second_y, second_vx, second_vy};
		dx_s1   <= {second_x[15], second_x} - {first_x[15], first_x};
		dy_s1   <= {second_y[15], second_y} - {first_y[15], first_y};
		dvx_s1  <= {first_vx[15], first_vx} - {second_vx[15], second_vx};
		dvy_s1  <= {first_vy[15], first_vy} - {second_vy[15], second_vy};
		dsum_s1 <= {1'b0, first_diameter} + {1'b0, second_diameter};
	end

	// ---- stage 2: squares and dot-product terms ----
	// when the discs overlap |dx|, |dy| < 4096, so 13 bits carry them
	logic signed [12:0] dxn_s1, dyn_s1;
	assign dxn_s1 = dx_s1[12:0];
	assign dyn_s1 = dy_s1[12:0];

	dcr_item_t          item_s2;
	logic [33:0]        dxx_s2, dyy_s2;
	logic [25:0]        dss_s2;
	logic signed [29:0] pvx_s2, pvy_s2;
	logic signed [12:0] dx_s2, dy_s2;
	logic [12:0]        dsum_s2;

	always_ff @(posedge clk) begin
		item_s2 <= item_s1;
		dxx_s2  <= dx_s1 * dx_s1;
		dyy_s2  <= dy_s1 * dy_s1;
		dss_s2  <= dsum_s1 * dsum_s1;
		pvx_s2  <= dvx_s1 * dxn_s1;
		pvy_s2  <= dvy_s1 * dyn_s1;
		dx_s2   <= dxn_s1;
		dy_s2   <= dyn_s1;
		dsum_s2 <= dsum_s1;
	end

	// ---- stage 3: overlap test, feeds the root pipeline ----
	logic [34:0]        dsq;
	logic signed [30:0] dot;
	logic               coll;

	assign dsq  = {1'b0, dxx_s2} + {1'b0, dyy_s2};
	assign dot  = 31'(pvx_s2) + 31'(pvy_s2);
	assign coll = (dsq != '0) && ({dsq, 2'b00} < {11'b0, dss_s2});

	dcr_sq_t sq_s [0:SQ_N];

	always_ff @(posedge clk) begin
		sq_s[0].geo.item  <= item_s2;
		sq_s[0].geo.dsum  <= dsum_s2;
		sq_s[0].geo.dx    <= dx_s2;
		sq_s[0].geo.dy    <= dy_s2;
		sq_s[0].geo.dist2 <= dsq[23:0];
		sq_s[0].geo.dot   <= dot;
		sq_s[0].geo.coll  <= coll;
		sq_s[0].geo.imp   <= coll && !dot[30] && (dot != '0);
		sq_s[0].rem       <= '0;
		sq_s[0].root      <= '0;
		sq_s[0].rad       <= {dsq[23:0], 16'b0};
	end

	// ---- root of dist2 * 65536, two radicand bits per stage ----
	for (genvar i = 1; i <= SQ_N; i++) begin : g_sq
		logic [SQREM_W:0] pre, trial;
		logic             ge;
		assign pre   = {sq_s[i-1].rem[SQREM_W-2:0], sq_s[i-1].rad[RAD_W-1:RAD_W-2]};
		assign trial = {1'b0, sq_s[i-1].root, 2'b01};
		assign ge    = pre >= trial;
		always_ff @(posedge clk) begin
			sq_s[i].geo  <= sq_s[i-1].geo;
			sq_s[i].rem  <= ge ? SQREM_W'(pre - trial) : SQREM_W'(pre);
			sq_s[i].root <= {sq_s[i-1].root[ROOT_W-2:0], ge};
			sq_s[i].rad  <= sq_s[i-1].rad << 2;
		end
	end

	// ---- stage 24: overlap in Q.8 ----
	dcr_geo_t          geo_s24;
	logic [ROOT_W-1:0] dist_s24;
	logic [19:0]       ovl_s24;

	always_ff @(posedge clk) begin
		geo_s24  <= sq_s[SQ_N].geo;
		dist_s24 <= sq_s[SQ_N].root;
		ovl_s24  <= {sq_s[SQ_N].geo.dsum, 7'b0} - sq_s[SQ_N].root;
	end

	// ---- stage 25: scaled overlap, impulse numerators ----
	dcr_geo_t           geo_s25;
	logic [ROOT_W-1:0]  dist_s25;
	logic [28:0]        k_s25;
	logic signed [INUM_W-1:0] pix_s25, piy_s25;

	always_ff @(posedge clk) begin
		geo_s25  <= geo_s24;
		dist_s25 <= dist_s24;
		k_s25    <= ovl_s24 * cf_q;
		pix_s25  <= geo_s24.dot * geo_s24.dx;
		piy_s25  <= geo_s24.dot * geo_s24.dy;
	end

	// ---- stage 26: push-out numerators and divisor ----
	dcr_geo_t                 geo_s26;
	logic signed [PNUM_W-1:0] pnx_s26, pny_s26;
	logic [PDEN_W-1:0]        den_s26;
	logic signed [INUM_W-1:0] pix_s26, piy_s26;
	logic signed [29:0]       ks;

	assign ks = {1'b0, k_s25};

	always_ff @(posedge clk) begin
		geo_s26 <= geo_s25;
		pnx_s26 <= ks * geo_s25.dx;
		pny_s26 <= ks * geo_s25.dy;
		den_s26 <= {dist_s25, 9'b0};
		pix_s26 <= pix_s25;
		piy_s26 <= piy_s25;
	end

	// ---- dividers ----
	logic signed [QUO_W:0] sx, sy, ix, iy;

	dcr_div_pipe #(.NUM_W(PNUM_W), .DEN_W(PDEN_W), .QUO_W(QUO_W)) u_div_sx (
		.clk(clk), .num(pnx_s26), .den(den_s26), .quo(sx));
	dcr_div_pipe #(.NUM_W(PNUM_W), .DEN_W(PDEN_W), .QUO_W(QUO_W)) u_div_sy (
		.clk(clk), .num(pny_s26), .den(den_s26), .quo(sy));
	dcr_div_pipe #(.NUM_W(INUM_W), .DEN_W(IDEN_W), .QUO_W(QUO_W)) u_div_ix (
		.clk(clk), .num(pix_s26), .den(geo_s26.dist2), .quo(ix));
	dcr_div_pipe #(.NUM_W(INUM_W), .DEN_W(IDEN_W), .QUO_W(QUO_W)) u_div_iy (
		.clk(clk), .num(piy_s26), .den(geo_s26.dist2), .quo(iy));

	// hold the pass-through data alongside the dividers
	dcr_tail_t tail_s [0:DIV_LAT-1];

	always_ff @(posedge clk) begin
		tail_s[0] <= '{geo_s26.item, geo_s26.coll, geo_s26.imp};
		for (int n = 1; n < DIV_LAT; n++) begin
			tail_s[n] <= tail_s[n-1];
		end
	end

	// ---- output stage ----
	dcr_tail_t t;
	assign t = tail_s[DIV_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_s[LAT-2];
		end
	end

	always_ff @(posedge clk) begin
		collided        <= t.coll;
		impulse_applied <= t.imp;
		if (t.coll) begin
			new_first_x  <= sat16(20'(t.item.x1) - 20'(sx));
			new_first_y  <= sat16(20'(t.item.y1) - 20'(sy));
			new_second_x <= sat16(20'(t.item.x2) + 20'(sx));
			new_second_y <= sat16(20'(t.item.y2) + 20'(sy));
		end else begin
			new_first_x  <= t.item.x1;
			new_first_y  <= t.item.y1;
			new_second_x <= t.item.x2;
			new_second_y <= t.item.y2;
		end
		if (t.imp) begin
			new_first_vx  <= sat16(20'(t.item.vx1) - 20'(ix));
			new_first_vy  <= sat16(20'(t.item.vy1) - 20'(iy));
			new_second_vx <= sat16(20'(t.item.vx2) + 20'(ix));
			new_second_vy <= sat16(20'(t.item.vy2) + 20'(iy));
		end else begin
			new_first_vx  <= t.item.vx1;
			new_first_vy  <= t.item.vy1;
			new_second_vx <= t.item.vx2;
			new_second_vy <= t.item.vy2;
		end
	end

`ifndef ASSERT_OFF
	a_imp_needs_coll: assert property (@(posedge clk) disable iff (!arst_n)
		done && impulse_applied |-> collided)
		else $error("impulse applied without collision");

	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result beat without a pair taken LAT cycles earlier");

	a_root_coll: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[SQ_N+2] && sq_s[SQ_N].geo.coll |-> sq_s[SQ_N].root != '0)
		else $error("colliding pair with zero distance after root");
`endif

endmodule
